// File: sv/lkv_pkg.sv
// Shared constants, types and codes for the LRU key-value cache.
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic exec;
  } lkv_cmd_t;

endpackage

// File: sv/lkv_ctrl.sv
// Controller: sequences each transaction and owns the input and output channel handshakes.
module lkv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lkv_pkg::lkv_cmd_t cmd
);
  import lkv_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    in_ready       = 1'b0;
    cmd            = '0;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // Hold until the result register is free or being drained
        if (!out_valid || out_ready) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/lkv_datapath.sv
// Datapath: entry storage, parallel key match, recency ranks and result register.
module lkv_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  lkv_pkg::lkv_cmd_t           cmd,
  input  logic                        cfg_valid,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_data,
  input  logic                        op,
  input  logic signed [lkv_pkg::KEY_W-1:0] lookup_key,
  input  logic signed [lkv_pkg::VAL_W-1:0] write_value,
  output logic                        hit,
  output logic signed [lkv_pkg::VAL_W-1:0] read_value,
  output logic                        evicted,
  output logic signed [lkv_pkg::KEY_W-1:0] evicted_key
);
  import lkv_pkg::*;

  logic [KEY_W-1:0]  keys   [ENTRIES];
  logic [VAL_W-1:0]  values [ENTRIES];
  logic [RANK_W-1:0] rank   [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [OCC_W-1:0]  occupancy;
  logic [CAP_W-1:0]  capacity;

  logic              op_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] lru_sel;
  logic [ENTRIES-1:0] valid_after;
  logic               is_hit;
  logic               do_evict;
  logic               has_free;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   lru_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [RANK_W-1:0]  hit_rank;
  logic [OCC_W-1:0]   occ_dec;
  logic [CMP_W-1:0]   eff_cap;
  logic [OCC_W-1:0]   occupancy_next;

  // Capacity register, written by the configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(16);
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op;
      key_q <= lookup_key;
      val_q <= write_value;
    end
  end

  // Clamp capacity to 1 .. ENTRIES
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
  end

  // Match keys and pick the least recent entry (rank occupancy-1)
  assign occ_dec = occupancy - 1'b1;
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]   = valid[i] && (keys[i] == key_q);
      lru_sel[i] = valid[i] && (rank[i] == occ_dec[RANK_W-1:0]);
    end
  end

  // Encode hit and victim slots
  always_comb begin
    hit_idx = '0;
    lru_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (lru_sel[i]) begin
        lru_idx = IDX_W'(i);
      end
    end
  end

  assign is_hit   = |match;
  assign hit_rank = rank[hit_idx];
  assign do_evict = (op_q == OP_PUT) && !is_hit && (occupancy != '0) &&
                    (CMP_W'(occupancy) >= eff_cap);

  // Drop the victim, then find the first free slot
  always_comb begin
    valid_after = valid;
    if (do_evict) begin
      valid_after[lru_idx] = 1'b0;
    end
    free_idx = '0;
    has_free = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_after[i]) begin
        free_idx = IDX_W'(i);
        has_free = 1'b1;
      end
    end
  end

  // Net occupancy change of a put that misses
  always_comb begin
    occupancy_next = occupancy;
    if (do_evict) begin
      occupancy_next = occupancy_next - 1'b1;
    end
    if (has_free) begin
      occupancy_next = occupancy_next + 1'b1;
    end
  end

  // Update valid bits, ranks and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occupancy <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (is_hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid[i] && (rank[i] < hit_rank)) begin
            rank[i] <= rank[i] + 1'b1;
          end
          if (IDX_W'(i) == hit_idx) begin
            rank[i] <= '0;
          end
        end
      end else if (op_q == OP_PUT) begin
        valid     <= valid_after;
        occupancy <= occupancy_next;
        for (int i = 0; i < ENTRIES; i++) begin
          if (do_evict && (IDX_W'(i) == lru_idx)) begin
            rank[i] <= '0;
          end
          if (has_free && valid_after[i]) begin
            rank[i] <= rank[i] + 1'b1;
          end
          if (has_free && (IDX_W'(i) == free_idx)) begin
            rank[i]  <= '0;
            valid[i] <= 1'b1;
          end
        end
      end
    end
  end

  // Write key and value storage
  always_ff @(posedge clk) begin
    if (cmd.exec && (op_q == OP_PUT)) begin
      if (is_hit) begin
        values[hit_idx] <= val_q;
      end else if (has_free) begin
        keys[free_idx]   <= key_q;
        values[free_idx] <= val_q;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      hit         <= is_hit;
      evicted     <= do_evict;
      evicted_key <= do_evict ? keys[lru_idx] : '0;
      if (op_q == OP_GET) begin
        read_value <= is_hit ? values[hit_idx] : MISS_VALUE;
      end else begin
        read_value <= '0;
      end
    end
  end

endmodule

// File: sv/lru_key_value_cache.sv
// Top level of the LRU key-value cache: controller plus datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries op, lookup_key and write_value.
//   op selects get (lookup) or put (insert or update). Every transaction
//   produces exactly one result on the output channel (out_valid/out_ready):
//   hit, read_value, evicted and evicted_key.
//   The configuration channel (cfg_valid/cfg_ready, cfg_data) writes the
//   capacity register; it is always ready. Write it only while idle.
// Operation:
//   The accepting edge captures the input transaction; the execute step then
//   matches all 16 keys in parallel, updates the recency ranks and loads the
//   result register. A new transaction is taken only after the previous one
//   has executed; the next item depends on those updated ranks.
// Reset:
//   Clears all valid bits, ranks and occupancy, and sets capacity to 16.
// Stalls:
//   A new item may be accepted while a result waits in the output register;
//   it is held in the execute cycle until out_ready drains that result.
module lru_key_value_cache (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic signed [lkv_pkg::KEY_W-1:0] lookup_key,
  input  logic signed [lkv_pkg::VAL_W-1:0] write_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit,
  output logic signed [lkv_pkg::VAL_W-1:0] read_value,
  output logic                             evicted,
  output logic signed [lkv_pkg::KEY_W-1:0] evicted_key,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]        cfg_data
);
  import lkv_pkg::*;

  lkv_cmd_t cmd;

  // Configuration writes are always accepted
  assign cfg_ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lkv_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .op          (op),
    .lookup_key  (lookup_key),
    .write_value (write_value),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the LRU key-value cache: directed, random and backpressure traffic.
module tb;
  import lkv_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int RUN_LIMIT    = 3_000_000;

  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

  typedef struct {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } access_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    op = OP_GET;
  logic signed [KEY_W-1:0] lookup_key = '0;
  logic signed [VAL_W-1:0] write_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CAP_W-1:0]        cfg_data = '0;

  // Cache image kept by the testbench
  logic [KEY_W-1:0] slot_key   [ENTRIES];
  logic [VAL_W-1:0] slot_value [ENTRIES];
  bit               slot_valid [ENTRIES] = '{default: 1'b0};
  int               slot_rank  [ENTRIES] = '{default: 0};
  int               occupancy = 0;
  logic [CAP_W-1:0] capacity_reg = CAP_W'(ENTRIES);

  access_result_t   pending_results[$];
  logic [KEY_W-1:0] key_pool[$];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_output    = 1'b0;
  int  items_sent     = 0;
  int  results_seen   = 0;
  int  mismatches     = 0;
  int  n_hits         = 0;
  int  n_evictions    = 0;
  int  n_cfg_writes   = 0;

  lru_key_value_cache i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .lookup_key  (lookup_key),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Apply one get or put to the cache image and return the result it produces
  function automatic access_result_t cache_access(input logic op_i,
                                                  input logic [KEY_W-1:0] key_i,
                                                  input logic [VAL_W-1:0] val_i);
    access_result_t res;
    int slot;
    int oldest;
    int free_slot;
    int limit;
    int promoted;
    res = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
    slot = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && slot_key[i] == key_i && slot < 0) slot = i;

    if (slot >= 0) begin
      // Hit: read or overwrite, then promote to most recent
      res.hit = 1'b1;
      if (op_i == OP_GET) res.read_value = slot_value[slot];
      else slot_value[slot] = val_i;
      promoted = slot_rank[slot];
      for (int i = 0; i < ENTRIES; i++)
        if (slot_valid[i] && slot_rank[i] < promoted) slot_rank[i]++;
      slot_rank[slot] = 0;
    end else if (op_i == OP_GET) begin
      res.read_value = MISS_VALUE;
    end else begin
      // New key: evict the oldest entry once the cache is at capacity
      limit = (capacity_reg == 0) ? 1 :
              (int'(capacity_reg) > ENTRIES) ? ENTRIES : int'(capacity_reg);
      if (occupancy >= limit) begin
        oldest = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (slot_valid[i] && (oldest < 0 || slot_rank[i] >= slot_rank[oldest])) oldest = i;
        if (oldest >= 0) begin
          res.evicted     = 1'b1;
          res.evicted_key = slot_key[oldest];
          slot_valid[oldest] = 1'b0;
          slot_rank[oldest]  = 0;
          if (occupancy > 0) occupancy--;
        end
      end
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (!slot_valid[i] && free_slot < 0) free_slot = i;
      if (free_slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_valid[i]) slot_rank[i]++;
        slot_key[free_slot]   = key_i;
        slot_value[free_slot] = val_i;
        slot_valid[free_slot] = 1'b1;
        slot_rank[free_slot]  = 0;
        occupancy++;
      end
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Track config writes and accepted items, check each result against the oldest prediction
  always @(posedge clk) begin
    access_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) capacity_reg = cfg_data;
      if (in_valid && in_ready)
        pending_results.push_back(cache_access(op, lookup_key, write_value));
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with no transaction outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (want.hit) n_hits++;
          if (want.evicted) n_evictions++;
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("read_value", want.read_value, read_value);
          check_field("evicted", 32'(want.evicted), 32'(evicted));
          check_field("evicted_key", want.evicted_key, evicted_key);
        end
      end
    end
  end

  // Drive out_ready: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one transaction; each cycle before it idles with the sender's idle rate,
  // and valid stays high into the next call when no idle cycle follows
  task automatic send_item(input logic op_i, input logic [KEY_W-1:0] key_i,
                           input logic [VAL_W-1:0] val_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= op_i;
    lookup_key  <= key_i;
    write_value <= val_i;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Wait for every outstanding result, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg_writes++;
  endtask

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(7))
      0:       return '0;                                     // behaves as one entry
      1:       return CAP_W'($urandom_range(31, ENTRIES + 1)); // saturates at full size
      2:       return CAP_W'(ENTRIES);
      3:       return CAP_W'(1);
      default: return CAP_W'($urandom_range(ENTRIES, 1));
    endcase
  endfunction

  // Draw a working set of keys so that hits and evictions both stay frequent
  function automatic void build_key_pool();
    int n;
    n = $urandom_range(24, 2);
    key_pool.delete();
    if ($urandom_range(3) == 0) begin
      key_pool.push_back(KEY_MIN);
      key_pool.push_back(KEY_MAX);
      key_pool.push_back('0);
      key_pool.push_back('1);
    end
    while (key_pool.size() < n) key_pool.push_back(KEY_W'($urandom()));
  endfunction

  task automatic send_random_item();
    logic [KEY_W-1:0] key;
    key = ($urandom_range(9) == 0) ? KEY_W'($urandom())
                                   : key_pool[$urandom_range(key_pool.size() - 1)];
    send_item(($urandom_range(1) == 1) ? OP_PUT : OP_GET, key, VAL_W'($urandom()));
  endtask

  // Reset capacity, extreme keys and values, miss on empty, update in place
  task automatic test_basic_access();
    send_item(OP_GET, '0, '0);
    send_item(OP_PUT, KEY_MIN, KEY_MAX);
    send_item(OP_PUT, KEY_MAX, KEY_MIN);
    send_item(OP_PUT, '1, 32'ha5a5_a5a5);
    send_item(OP_PUT, '0, '0);
    send_item(OP_GET, KEY_MIN, '1);
    send_item(OP_GET, KEY_MAX, '0);
    send_item(OP_GET, '1, '0);
    send_item(OP_GET, '0, '0);
    send_item(OP_PUT, '0, 32'h5a5a_5a5a);
    send_item(OP_GET, '0, '0);
  endtask

  // Drop capacity below occupancy: each new key evicts just one entry
  task automatic test_lowered_capacity();
    write_capacity(CAP_W'(2));
    send_item(OP_GET, KEY_MIN, '0);
    send_item(OP_PUT, 32'h0000_0100, 32'h1111_1111);
    send_item(OP_PUT, 32'h0000_0200, 32'h2222_2222);
    send_item(OP_GET, 32'h0000_0100, '0);
    send_item(OP_PUT, 32'h0000_0300, 32'h3333_3333);
  endtask

  // Capacity zero acts as one entry; anything above the array size saturates
  task automatic test_capacity_limits();
    write_capacity('0);
    send_item(OP_PUT, 32'h0000_0400, 32'h4444_4444);
    send_item(OP_PUT, 32'h0000_0500, 32'h5555_5555);
    send_item(OP_GET, 32'h0000_0400, '0);
    write_capacity('1);
    send_item(OP_PUT, 32'h0000_0600, 32'h6666_6666);
    send_item(OP_PUT, 32'h0000_0700, 32'h7777_7777);
  endtask

  // Random gets and puts over changing capacities and working sets
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input int n_items);
    int done;
    int segment;
    send_idle_pct  = sender_idle;
    recv_stall_pct = receiver_stall;
    done = 0;
    while (done < n_items) begin
      write_capacity(pick_capacity());
      build_key_pool();
      segment = $urandom_range(90, 40);
      repeat (segment) send_random_item();
      done += segment;
    end
  endtask

  // Hold off the result side while items keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_capacity(CAP_W'($urandom_range(8, 2)));
    build_key_pool();
    hold_output = 1'b1;
    repeat (24) send_random_item();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_basic_access();
    test_lowered_capacity();
    test_capacity_limits();
    test_random_traffic(24, 79, 400);
    test_random_traffic(79, 24, 400);
    test_random_traffic(0, 0, 400);
    test_backpressure();
    wait_idle();
    $display("Checked %0d transactions (%0d hits, %0d evictions) over %0d capacity writes,",
             results_seen, n_hits, n_evictions, n_cfg_writes);
    $display("with sender gaps, receiver stalls and a long output hold-off.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
